// File: hdl/assert_macros.svh
// Assertion macros for the RTL files; only the top-level stage includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define IDWT_ASSERT(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define IDWT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/idwt_pkg.sv
// Types, widths and register codes of the inverse wavelet synthesis stage.
`default_nettype none
package idwt_pkg;

   localparam int DEFAULT_TAPS = 4;
   localparam int MAX_TAPS     = 4;
   localparam int PHASES       = 2;
   localparam int MAX_CELLS    = (MAX_TAPS + 1) / 2;

   localparam int COEF_W    = 18;
   localparam int TAP_W     = 16;
   localparam int SAMPLE_W  = 20;
   localparam int FRAC_BITS = 14;
   localparam int PROD_W    = COEF_W + TAP_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int ACC_W     = PAIR_W + $clog2(MAX_CELLS) + 1;

   localparam int SAMPLE_MAX = 524287;
   localparam int SAMPLE_MIN = -524288;

   localparam int CSR_IDX_W = 3;
   localparam int TAP_IDX_W = $clog2(MAX_TAPS);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LOW_TAP_0  = 3'd0,
      REG_LOW_TAP_1  = 3'd1,
      REG_LOW_TAP_2  = 3'd2,
      REG_LOW_TAP_3  = 3'd3,
      REG_HIGH_TAP_0 = 3'd4,
      REG_HIGH_TAP_1 = 3'd5,
      REG_HIGH_TAP_2 = 3'd6,
      REG_HIGH_TAP_3 = 3'd7
   } csr_reg_type;

   typedef logic signed [TAP_W-1:0] tap_array_type [MAX_TAPS];

   typedef struct packed {
      logic signed [COEF_W-1:0] approx;
      logic signed [COEF_W-1:0] detail;
   } coef_pair_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic phase;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// File: hdl/inverse_dwt_synthesis_1d.sv
// Inverse wavelet synthesis stage: one coefficient pair in, up to two samples out.
//
// Usage: req_ carries one approximation/detail coefficient pair per transfer,
// with req_end_of_signal on the final pair. rsp_ carries one reconstructed
// sample per transfer, the even phase first; rsp_last_in_item marks the last
// sample of a pair and rsp_last_of_signal the final sample of the signal.
// The first TAPS-2 samples of each signal are dropped.
// Taps are written through csr_ (index 0..3 low-pass, 4..7 high-pass); the user
// must write them only while idle; the block itself does not enforce it.
// A pair passes the product stage and then the output register; rsp_ takes one
// sample per cycle while rsp_ready is high, so two samples of a pair go in turn.
// A pair holds in the product stage while rsp_ stalls; req_ready stays high
// whenever that stage is free or drains in the same cycle.
// Reset clears taps, histories, the startup count and both valid flags.
`default_nettype none
module inverse_dwt_synthesis_1d
   import idwt_pkg::*;
#(
   parameter int TAPS = DEFAULT_TAPS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [COEF_W-1:0]   req_approx_coef,
   input  wire logic signed [COEF_W-1:0]   req_detail_coef,
   input  wire logic                       req_end_of_signal,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0]      rsp_sample,
   output logic                            rsp_last_in_item,
   output logic                            rsp_last_of_signal,
   input  wire logic                       csr_wen,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [TAP_W-1:0]           csr_wdata
);

`include "assert_macros.svh"

   localparam int NCELL  = (TAPS + 1) / 2;
   localparam int SKIP   = TAPS - 2;
   localparam int SKIP_W = ($clog2(TAPS - 1) > 0) ? $clog2(TAPS - 1) : 1;
   localparam int SH_W   = ACC_W - FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_BITS - 1));
   localparam logic signed [SH_W-1:0]  SH_MAX     = SH_W'(SAMPLE_MAX);
   localparam logic signed [SH_W-1:0]  SH_MIN     = SH_W'(SAMPLE_MIN);
   localparam logic [SKIP_W-1:0]       SKIP_LIM   = SKIP_W'(SKIP);

   tap_array_type lo_tap_ff, lo_tap_in;
   tap_array_type hi_tap_ff, hi_tap_in;

   logic [SKIP_W-1:0] skip_ff, skip_in, skip_mid;
   logic              emit0, emit1;

   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_emit_ff, s1_emit_in;
   logic              s1_last_ff, s1_last_in;
   logic              phase_ff, phase_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_lii_ff, rsp_lii_in;
   logic                       rsp_los_ff, rsp_los_in;

   logic accept, out_free, s1_any, s1_final_phase, send, s1_done;

   cell_ctrl_type             ctrl;
   coef_pair_type             coef_chain [NCELL];
   logic signed [ACC_W-1:0]   psum_chain [NCELL+1];
   logic signed [SH_W-1:0]    shifted;
   logic signed [SAMPLE_W-1:0] sat_sample;

   // Configuration
   always_comb begin
      lo_tap_in = lo_tap_ff;
      hi_tap_in = hi_tap_ff;
      if (csr_wen) begin
         if (csr_index inside {[REG_LOW_TAP_0:REG_LOW_TAP_3]}) begin
            lo_tap_in[csr_index[TAP_IDX_W-1:0]] = $signed(csr_wdata);
         end else if (csr_index inside {[REG_HIGH_TAP_0:REG_HIGH_TAP_3]}) begin
            hi_tap_in[csr_index[TAP_IDX_W-1:0]] = $signed(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_tap_ff <= '{default: '0};
         hi_tap_ff <= '{default: '0};
      end else begin
         lo_tap_ff <= lo_tap_in;
         hi_tap_ff <= hi_tap_in;
      end
   end

   // Handshake and stage control
   assign accept         = req_valid & req_ready;
   assign out_free       = ~rsp_valid_ff | rsp_ready;
   assign s1_any         = |s1_emit_ff;
   assign s1_final_phase = phase_ff | ~s1_emit_ff[1];
   assign send           = s1_valid_ff & s1_any & out_free;
   assign s1_done        = s1_valid_ff & (~s1_any | (out_free & s1_final_phase));
   assign req_ready      = ~s1_valid_ff | s1_done;

   // Startup drop count
   always_comb begin
      emit0    = (skip_ff >= SKIP_LIM);
      skip_mid = emit0 ? skip_ff : SKIP_W'(skip_ff + 1'b1);
      emit1    = (skip_mid >= SKIP_LIM);
      skip_in  = skip_ff;
      if (accept) begin
         if (req_end_of_signal) begin
            skip_in = '0;
         end else begin
            skip_in = emit1 ? skip_mid : SKIP_W'(skip_mid + 1'b1);
         end
      end
   end

   always_comb begin
      s1_valid_in = accept | (s1_valid_ff & ~s1_done);
      s1_emit_in  = s1_emit_ff;
      s1_last_in  = s1_last_ff;
      phase_in    = phase_ff;
      if (accept) begin
         s1_emit_in = {emit1, emit0};
         s1_last_in = req_end_of_signal;
         phase_in   = ~emit0;
      end else if (send) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= '0;
         s1_last_ff  <= 1'b0;
         phase_ff    <= 1'b0;
      end else begin
         skip_ff     <= skip_in;
         s1_valid_ff <= s1_valid_in;
         s1_emit_ff  <= s1_emit_in;
         s1_last_ff  <= s1_last_in;
         phase_ff    <= phase_in;
      end
   end

   // Cell row
   assign ctrl.load  = accept;
   assign ctrl.clear = accept & req_end_of_signal;
   assign ctrl.phase = phase_ff;

   assign coef_chain[0].approx = req_approx_coef;
   assign coef_chain[0].detail = req_detail_coef;
   assign psum_chain[0]        = ROUND_BIAS;

   generate
      for (genvar k = 0; k < NCELL; k++) begin : g_cell
         if (k < NCELL - 1) begin : g_mid
            idwt_cell #(
               .TAPS     (TAPS),
               .CELL_IDX (k)
            ) u_cell (
               .clock    (clock),
               .reset    (reset),
               .ctrl     (ctrl),
               .coef_in  (coef_chain[k]),
               .lo_taps  (lo_tap_ff),
               .hi_taps  (hi_tap_ff),
               .psum_in  (psum_chain[k]),
               .coef_out (coef_chain[k+1]),
               .psum_out (psum_chain[k+1])
            );
         end else begin : g_tail
            idwt_cell #(
               .TAPS     (TAPS),
               .CELL_IDX (k)
            ) u_cell (
               .clock    (clock),
               .reset    (reset),
               .ctrl     (ctrl),
               .coef_in  (coef_chain[k]),
               .lo_taps  (lo_tap_ff),
               .hi_taps  (hi_tap_ff),
               .psum_in  (psum_chain[k]),
               .coef_out (),
               .psum_out (psum_chain[k+1])
            );
         end
      end
   endgenerate

   // Round and saturate
   always_comb begin
      shifted = $signed(psum_chain[NCELL][ACC_W-1:FRAC_BITS]);
      if (shifted > SH_MAX) begin
         sat_sample = SAMPLE_W'(SAMPLE_MAX);
      end else if (shifted < SH_MIN) begin
         sat_sample = SAMPLE_W'(SAMPLE_MIN);
      end else begin
         sat_sample = shifted[SAMPLE_W-1:0];
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in  = send | (rsp_valid_ff & ~rsp_ready);
      rsp_sample_in = rsp_sample_ff;
      rsp_lii_in    = rsp_lii_ff;
      rsp_los_in    = rsp_los_ff;
      if (send) begin
         rsp_sample_in = sat_sample;
         rsp_lii_in    = s1_final_phase;
         rsp_los_in    = s1_final_phase & s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sample_ff <= rsp_sample_in;
      rsp_lii_ff    <= rsp_lii_in;
      rsp_los_ff    <= rsp_los_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample         = rsp_sample_ff;
   assign rsp_last_in_item   = rsp_lii_ff;
   assign rsp_last_of_signal = rsp_los_ff;

   // Assertions
   `IDWT_ASSERT(a_los_marks_item_end, clock, reset,
      !(rsp_valid && rsp_last_of_signal) || rsp_last_in_item,
      "last_of_signal without last_in_item")
   `IDWT_ASSERT_NEXT(a_second_phase_follows, clock, reset,
      send && !s1_final_phase, s1_valid_ff && phase_ff,
      "even phase sent but odd phase lost")
   `IDWT_ASSERT(a_skip_bounded, clock, reset, skip_ff <= SKIP_LIM,
      "startup count beyond drop length")
   `IDWT_ASSERT_NEXT(a_end_clears_skip, clock, reset,
      accept && req_end_of_signal, skip_ff == '0,
      "startup count not cleared after end of signal")

endmodule
`default_nettype wire

// File: hdl/idwt_cell.sv
// One polyphase cell: pair history (in every cell but cell 0), per-phase products and partial-sum stage.
`default_nettype none
module idwt_cell
   import idwt_pkg::*;
#(
   parameter int TAPS     = DEFAULT_TAPS,
   parameter int CELL_IDX = 0
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cell_ctrl_type            ctrl,
   input  wire coef_pair_type            coef_in,
   input  wire tap_array_type            lo_taps,
   input  wire tap_array_type            hi_taps,
   input  wire logic signed [ACC_W-1:0]  psum_in,
   output coef_pair_type                 coef_out,
   output logic signed [ACC_W-1:0]       psum_out
);

   coef_pair_type           coef;
   logic signed [PAIR_W-1:0] prod_ff [PHASES];
   logic signed [PAIR_W-1:0] prod_in [PHASES];

   generate
      if (CELL_IDX == 0) begin : g_head
         assign coef = coef_in;
      end else begin : g_hist
         coef_pair_type hist_ff;
         coef_pair_type hist_in;

         always_comb begin
            hist_in = hist_ff;
            if (ctrl.load) begin
               hist_in = ctrl.clear ? '0 : coef_in;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               hist_ff <= '0;
            end else begin
               hist_ff <= hist_in;
            end
         end

         assign coef = hist_ff;
      end
   endgenerate

   assign coef_out = coef;

   generate
      for (genvar p = 0; p < PHASES; p++) begin : g_phase
         localparam int IDX = 2 * CELL_IDX + p;
         logic signed [TAP_W-1:0]  lo_t;
         logic signed [TAP_W-1:0]  hi_t;
         logic signed [PROD_W-1:0] prod_a;
         logic signed [PROD_W-1:0] prod_d;

         if (IDX < TAPS) begin : g_tap
            assign lo_t = lo_taps[IDX];
            assign hi_t = hi_taps[IDX];
         end else begin : g_zero
            assign lo_t = '0;
            assign hi_t = '0;
         end

         assign prod_a     = coef.approx * lo_t;
         assign prod_d     = coef.detail * hi_t;
         assign prod_in[p] = ctrl.load ? (PAIR_W'(prod_a) + PAIR_W'(prod_d)) : prod_ff[p];
      end
   endgenerate

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign psum_out = psum_in + ACC_W'(prod_ff[ctrl.phase]);

endmodule
`default_nettype wire
